>>> rtl/lmtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_pkg
// Types, codes and arithmetic helpers of the log-MAP trellis decoder.
// ----------------------------------------------------------------------------
package lmtd_pkg;

   localparam int COL_SIZE = 8;

   typedef logic signed [15:0] metric_type;
   typedef metric_type [COL_SIZE-1:0] col_type;

   localparam metric_type NEG_METRIC = 16'sh8000;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] REG_END_STATE = 2'd0;
   localparam logic [1:0] REG_TRELLIS_LO = 2'd1;
   localparam logic [1:0] REG_TRELLIS_HI = 2'd2;

   typedef struct packed {
      logic clear;
      logic trans_en;
      logic delta_en;
      logic backward;
      logic first_half;
      logic max_en;
   } step_ctrl_type;

   function automatic logic [2:0] corr_lookup(input logic [4:0] idx);
      case (idx) inside
         5'd0:            return 3'd6;
         5'd1, 5'd2:      return 3'd5;
         5'd3, 5'd4:      return 3'd4;
         [5'd5:5'd8]:     return 3'd3;
         [5'd9:5'd12]:    return 3'd2;
         default:         return 3'd1;
      endcase
   endfunction

   function automatic logic signed [19:0] max_star(input logic signed [19:0] a,
                                                   input logic signed [19:0] b);
      logic signed [19:0] m;
      logic [19:0] d;
      logic [2:0] c;
      if (a > b) begin
         m = a;
         d = 20'(a - b);
      end else begin
         m = b;
         d = 20'(b - a);
      end
      c = (d < 20'd22) ? corr_lookup(d[4:0]) : 3'd0;
      return m + $signed({17'd0, c});
   endfunction

   function automatic metric_type sat16(input logic signed [20:0] v);
      if (v > 21'sd32767) return 16'sh7fff;
      if (v < -21'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [9:0] gamma_of(input logic [7:0] tb,
                                                  input logic [15:0] sym);
      logic signed [9:0] s;
      logic signed [9:0] p;
      s = tb[6] ? 10'($signed(sym[7:0])) : 10'sd0;
      p = tb[7] ? 10'($signed(sym[15:8])) : 10'sd0;
      return s + p;
   endfunction

   function automatic logic [7:0] trans_byte(input logic [63:0] lo,
                                             input logic [63:0] hi,
                                             input logic [3:0] t);
      return t[3] ? hi[8*t[2:0] +: 8] : lo[8*t[2:0] +: 8];
   endfunction

endpackage

>>> rtl/lmtd_col_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_col_unit
// Metric datapath: one trellis transition per cycle for a column step or a
// delta accumulation, column maximum and normalization, extrinsic output.
// ----------------------------------------------------------------------------
module lmtd_col_unit import lmtd_pkg::*; (
   input  logic          clock,
   input  step_ctrl_type ctrl,
   input  logic [7:0]    tbyte,
   input  logic [15:0]   sym,
   input  col_type       prev_col,
   input  col_type       alpha_row,
   output col_type       norm_col,
   output metric_type    llr
);

   logic signed [17:0] temp_ff [COL_SIZE];
   col_type            next_ff;
   logic signed [19:0] p0_ff, p1_ff;
   logic               set0_ff, set1_ff;
   metric_type         max_ff;

   logic [2:0]         from_st, to_st, src, dst;
   logic signed [9:0]  g;
   logic signed [17:0] v, d;
   logic signed [19:0] ms_a, ms_b, ms;
   metric_type         col_max;

   always_comb begin
      from_st = tbyte[2:0];
      to_st   = tbyte[5:3];
      src     = ctrl.backward ? to_st : from_st;
      dst     = ctrl.backward ? from_st : to_st;
      g       = gamma_of(tbyte, sym);
      v       = 18'($signed(prev_col[src])) + 18'(g);
      d       = 18'(g) + 18'($signed(alpha_row[from_st])) + 18'($signed(prev_col[to_st]));
      if (ctrl.delta_en) begin
         ms_a = tbyte[6] ? p1_ff : p0_ff;
         ms_b = 20'(d);
      end else begin
         ms_a = 20'(temp_ff[dst]);
         ms_b = 20'(v);
      end
      ms = max_star(ms_a, ms_b);
   end

   always_comb begin
      col_max = next_ff[0];
      for (int s = 1; s < COL_SIZE; s++) begin
         if ($signed(next_ff[s]) > $signed(col_max)) col_max = next_ff[s];
      end
      for (int s = 0; s < COL_SIZE; s++) begin
         norm_col[s] = sat16(21'($signed(next_ff[s])) - 21'($signed(max_ff)));
      end
      llr = sat16(21'(p1_ff) - 21'(p0_ff) - 21'($signed(sym[7:0])));
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         for (int s = 0; s < COL_SIZE; s++) begin
            temp_ff[s] <= 18'(NEG_METRIC);
            next_ff[s] <= NEG_METRIC;
         end
         p0_ff   <= 20'(NEG_METRIC);
         p1_ff   <= 20'(NEG_METRIC);
         set0_ff <= 1'b0;
         set1_ff <= 1'b0;
      end else if (ctrl.trans_en) begin
         if (ctrl.first_half) begin
            temp_ff[dst] <= v;
         end else begin
            next_ff[dst] <= sat16(21'(ms));
         end
      end else if (ctrl.delta_en) begin
         if (tbyte[6]) begin
            p1_ff   <= set1_ff ? ms : 20'(d);
            set1_ff <= 1'b1;
         end else begin
            p0_ff   <= set0_ff ? ms : 20'(d);
            set0_ff <= 1'b1;
         end
      end
      if (ctrl.max_en) begin
         max_ff <= col_max;
      end
   end

endmodule

>>> rtl/log_map_trellis_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_map_trellis_decoder_unit
// Log-MAP (BCJR) decoder for an 8-state binary trellis with software trellis.
// ----------------------------------------------------------------------------
// Load words (tuser = 0) are taken while no run is active; the load word with
// tlast starts a run and tready stays low until it ends. A run does the
// forward recursion over the symbols after the first, then the backward pass,
// which accumulates the deltas and writes an LLR for each symbol and steps the
// backward metrics between symbols; its run time is set by the metric unit
// that handles one transition per cycle. Drain words (tuser = 1) give their
// result through the LLR store read and the result register; loads are taken
// while a result waits. The stores need no clearing pass after reset. The
// trellis registers must be written before the first run.
// ----------------------------------------------------------------------------
module log_map_trellis_decoder_unit import lmtd_pkg::*; #(
   parameter int MAX_BLOCK  = 2048,
   parameter int NUM_STATES = 8,
   parameter int NUM_TRANS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // sys_llr[7:0], parity_llr[15:8]
   input  logic        req_tuser,  // opcode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // extrinsic_llr[15:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam int TW = $clog2(NUM_TRANS);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_F_WAIT  = 4'd1;
   localparam logic [3:0] S_F_TRANS = 4'd2;
   localparam logic [3:0] S_F_MAX   = 4'd3;
   localparam logic [3:0] S_F_NORM  = 4'd4;
   localparam logic [3:0] S_B_INIT  = 4'd5;
   localparam logic [3:0] S_B_WAIT  = 4'd6;
   localparam logic [3:0] S_B_DELTA = 4'd7;
   localparam logic [3:0] S_B_LLR   = 4'd8;
   localparam logic [3:0] S_B_TRANS = 4'd9;
   localparam logic [3:0] S_B_MAX   = 4'd10;
   localparam logic [3:0] S_B_NORM  = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] load_cnt_ff, load_cnt_in;
   logic [CW-1:0] drain_cnt_ff, drain_cnt_in;
   logic [CW-1:0] blen_ff, blen_in;
   logic          ready_ff, ready_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [TW-1:0] tr_ff, tr_in;
   logic [3:0]    end_state_ff;
   logic [63:0]   trel_lo_ff, trel_hi_ff;
   col_type       col_ff, col_in;
   col_type       beta_ff, beta_in;
   metric_type    rsp_data_ff;
   logic          rsp_last_ff;

   logic [15:0]   sym_mem [MAX_BLOCK];
   col_type       alpha_mem [MAX_BLOCK];
   metric_type    llr_mem [MAX_BLOCK];
   logic [15:0]   sym_q;
   col_type       alpha_q;
   metric_type    llr_q;

   logic          sym_we, alpha_we, llr_we;
   logic [AW-1:0] alpha_wa;
   col_type       alpha_wd;
   col_type       init_col;
   col_type       prev_col;
   col_type       norm_col;
   metric_type    llr;
   step_ctrl_type ctrl;
   logic [7:0]    tbyte;
   logic          req_fire;
   logic          tr_last;
   logic          not_full;
   logic [CW-1:0] blen_new;
   logic          at_end;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign req_tready = (state_ff == S_IDLE) && !pend_ff &&
                       (!rsp_valid_ff || req_tuser == OP_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign tr_last    = tr_ff == TW'(NUM_TRANS - 1);
   assign tbyte      = trans_byte(trel_lo_ff, trel_hi_ff, 4'(tr_ff));
   assign not_full   = load_cnt_ff < CW'(MAX_BLOCK);
   assign blen_new   = not_full ? load_cnt_ff + CW'(1) : CW'(MAX_BLOCK);
   assign at_end     = CW'(pos_ff) == blen_ff - CW'(1);

   always_comb begin
      for (int s = 0; s < COL_SIZE; s++) begin
         init_col[s] = (s == 0) ? 16'sd0 : NEG_METRIC;
      end
   end

   always_comb begin
      ctrl            = '0;
      ctrl.clear      = (state_ff == S_F_WAIT) || (state_ff == S_B_WAIT) ||
                        (state_ff == S_B_LLR);
      ctrl.trans_en   = (state_ff == S_F_TRANS) || (state_ff == S_B_TRANS);
      ctrl.delta_en   = state_ff == S_B_DELTA;
      ctrl.backward   = state_ff == S_B_TRANS;
      ctrl.first_half = 5'(tr_ff) < 5'(NUM_STATES);
      ctrl.max_en     = (state_ff == S_F_MAX) || (state_ff == S_B_MAX);
      prev_col        = (state_ff == S_F_TRANS) ? col_ff : beta_ff;
   end

   lmtd_col_unit u_col (
      .clock     (clock),
      .ctrl      (ctrl),
      .tbyte     (tbyte),
      .sym       (sym_q),
      .prev_col  (prev_col),
      .alpha_row (alpha_q),
      .norm_col  (norm_col),
      .llr       (llr)
   );

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      drain_cnt_in = drain_cnt_ff;
      blen_in      = blen_ff;
      ready_in     = ready_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in       = pos_ff;
      rd_addr_in   = rd_addr_ff;
      tr_in        = tr_ff;
      col_in       = col_ff;
      beta_in      = beta_ff;
      sym_we       = 1'b0;
      alpha_we     = 1'b0;
      alpha_wa     = pos_ff;
      alpha_wd     = norm_col;
      llr_we       = 1'b0;

      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == OP_LOAD) begin
               if (not_full) begin
                  sym_we      = 1'b1;
                  load_cnt_in = load_cnt_ff + CW'(1);
               end
               if (req_tlast) begin
                  blen_in     = blen_new;
                  load_cnt_in = '0;
                  ready_in    = 1'b0;
                  alpha_we    = 1'b1;
                  alpha_wa    = '0;
                  alpha_wd    = init_col;
                  col_in      = init_col;
                  pos_in      = AW'(1);
                  rd_addr_in  = '0;
                  state_in    = (blen_new == CW'(1)) ? S_B_INIT : S_F_WAIT;
               end
            end else if (req_fire && ready_ff && drain_cnt_ff < blen_ff) begin
               pend_in      = 1'b1;
               pend_last_in = drain_cnt_ff + CW'(1) == blen_ff;
               drain_cnt_in = drain_cnt_ff + CW'(1);
               if (drain_cnt_ff + CW'(1) >= blen_ff) ready_in = 1'b0;
            end
         end
         S_F_WAIT: begin
            tr_in    = '0;
            state_in = S_F_TRANS;
         end
         S_F_TRANS: begin
            tr_in = tr_ff + TW'(1);
            if (tr_last) state_in = S_F_MAX;
         end
         S_F_MAX: state_in = S_F_NORM;
         S_F_NORM: begin
            col_in   = norm_col;
            alpha_we = 1'b1;
            if (at_end) begin
               state_in = S_B_INIT;
            end else begin
               pos_in     = pos_ff + AW'(1);
               rd_addr_in = pos_ff;
               state_in   = S_F_WAIT;
            end
         end
         S_B_INIT: begin
            for (int s = 0; s < COL_SIZE; s++) begin
               beta_in[s] = 16'sd0;
            end
            if (end_state_ff >= 4'd1 && end_state_ff <= 4'(NUM_STATES)) begin
               for (int s = 0; s < COL_SIZE; s++) begin
                  beta_in[s] = (3'(s) == 3'(end_state_ff - 4'd1)) ? 16'sd0 : NEG_METRIC;
               end
            end
            pos_in     = AW'(blen_ff - CW'(1));
            rd_addr_in = AW'(blen_ff - CW'(1));
            state_in   = S_B_WAIT;
         end
         S_B_WAIT: begin
            tr_in    = '0;
            state_in = S_B_DELTA;
         end
         S_B_DELTA: begin
            tr_in = tr_ff + TW'(1);
            if (tr_last) state_in = S_B_LLR;
         end
         S_B_LLR: begin
            llr_we = 1'b1;
            tr_in  = '0;
            if (pos_ff == '0) begin
               ready_in     = 1'b1;
               drain_cnt_in = '0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_B_TRANS;
            end
         end
         S_B_TRANS: begin
            tr_in = tr_ff + TW'(1);
            if (tr_last) state_in = S_B_MAX;
         end
         S_B_MAX: state_in = S_B_NORM;
         S_B_NORM: begin
            beta_in    = norm_col;
            pos_in     = pos_ff - AW'(1);
            rd_addr_in = pos_ff - AW'(1);
            state_in   = S_B_WAIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_cnt_ff  <= '0;
         drain_cnt_ff <= '0;
         blen_ff      <= '0;
         ready_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         end_state_ff <= '0;
         trel_lo_ff   <= '0;
         trel_hi_ff   <= '0;
         for (int s = 0; s < COL_SIZE; s++) begin
            beta_ff[s] <= 16'sd0;
         end
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         drain_cnt_ff <= drain_cnt_in;
         blen_ff      <= blen_in;
         ready_ff     <= ready_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         beta_ff      <= beta_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_END_STATE:  end_state_ff <= csr_data[3:0];
               REG_TRELLIS_LO: trel_lo_ff   <= csr_data;
               REG_TRELLIS_HI: trel_hi_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      rd_addr_ff   <= rd_addr_in;
      tr_ff        <= tr_in;
      col_ff       <= col_in;
      pend_last_ff <= pend_last_in;
      if (pend_ff) begin
         rsp_data_ff <= llr_q;
         rsp_last_ff <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sym_we) sym_mem[load_cnt_ff[AW-1:0]] <= req_tdata;
      sym_q <= sym_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (alpha_we) alpha_mem[alpha_wa] <= alpha_wd;
      alpha_q <= alpha_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (llr_we) llr_mem[pos_ff] <= llr;
      llr_q <= llr_mem[drain_cnt_ff[AW-1:0]];
   end

endmodule

>>> rtl/lmtd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmtd_checker
// Port-level checks of the log-MAP trellis decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lmtd_checker import lmtd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [63:0] csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_valid, csr_ready, csr_index, csr_data};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser == OP_DRAIN, 2))
      else $error("result word without a drain two cycles earlier");

   a_drain_room: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_DRAIN |-> !rsp_tvalid)
      else $error("drain taken while a result waits");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_LOAD && req_tlast |=> !req_tready)
      else $error("input taken right after a run start");

endmodule

bind log_map_trellis_decoder_unit lmtd_checker u_lmtd_checker (.*);
